FILE: hw/rtl/rbsm_pkg.sv
package rbsm_pkg;

   localparam int unsigned SIZE_W    = 17;
   localparam int unsigned OFFSET_W  = 16;
   localparam int unsigned LENGTH_W  = 20;
   localparam int unsigned ROUND_W   = 21;
   localparam int unsigned ALIGN_W   = 4;
   localparam int unsigned STATUS_W  = 2;

   localparam logic [SIZE_W-1:0]  CAPACITY       = 17'd65536;
   localparam logic [ALIGN_W-1:0] MAX_ALIGN_LOG2 = 4'd8;

   // Register indexes on the configuration port.
   localparam logic CSR_ALIGN_LOG2  = 1'b0;
   localparam logic CSR_BUFFER_SIZE = 1'b1;

   // Request kinds.
   localparam logic ACT_RESERVE = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd2;

   typedef struct packed {
      logic [ALIGN_W-1:0] align_log2;
      logic [SIZE_W-1:0]  buffer_size;
   } cfg_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [OFFSET_W-1:0] start_offset;
      logic [SIZE_W-1:0]   granted;
      logic [OFFSET_W-1:0] read_offset;
      logic [SIZE_W-1:0]   unread_count;
      logic                read_ready;
   } result_type;

endpackage

FILE: hw/rtl/ring_buffer_space_manager.sv
// Space manager for a byte ring buffer of up to 65536 bytes. Each request on the
// req_ stream either reserves and commits write space or releases read bytes;
// every request yields exactly one response on the rsp_ stream, in order. A
// request is registered on entry and resolved once the response register is free
// or drains; the pointer update and the response are computed in one pass and
// the response is registered. One request is taken every cycle as long as
// responses are taken. Write the alignment and size registers on the
// csr_ port only while no request is outstanding.
module ring_buffer_space_manager
   import rbsm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // Request stream.
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [23:0]       req_tdata,  // [19:0] length, rest zero
   input  logic [0:0]        req_tuser,  // [0] action
   // Response stream.
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [71:0]       rsp_tdata,  // [15:0] start_offset, [32:16] granted,
                                         // [48:33] read_offset, [65:49] unread_count,
                                         // [66] read_ready, rest zero
   output logic [1:0]        rsp_tuser,  // [1:0] status
   // Configuration writes.
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [SIZE_W-1:0] csr_data
);

   cfg_type    cfg;
   result_type result;

   logic                in_valid_ff;
   logic                in_action_ff;
   logic [LENGTH_W-1:0] in_length_ff;
   logic                out_valid_ff;
   result_type          out_result_ff;
   logic                advance;

   rbsm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   rbsm_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (advance),
      .action (in_action_ff),
      .length (in_length_ff),
      .result (result)
   );

   // The held request resolves whenever the response register is free or drains.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_action_ff <= req_tuser[0];
         in_length_ff <= req_tdata[LENGTH_W-1:0];
      end
      if (advance) begin
         out_result_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_result_ff.status;
   assign rsp_tdata  = {5'b0,
                        out_result_ff.read_ready,
                        out_result_ff.unread_count,
                        out_result_ff.read_offset,
                        out_result_ff.granted,
                        out_result_ff.start_offset};

endmodule

FILE: hw/rtl/rbsm_csr.sv
module rbsm_csr
   import rbsm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_index,
   input  logic [SIZE_W-1:0] csr_data,
   output cfg_type           cfg
);

   logic [ALIGN_W-1:0] align_log2_ff;
   logic [SIZE_W-1:0]  buffer_size_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         align_log2_ff  <= '0;
         buffer_size_ff <= CAPACITY;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ALIGN_LOG2:  align_log2_ff  <= csr_data[ALIGN_W-1:0];
            CSR_BUFFER_SIZE: buffer_size_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign cfg.align_log2  = align_log2_ff;
   assign cfg.buffer_size = buffer_size_ff;

endmodule

FILE: hw/rtl/rbsm_engine.sv
module rbsm_engine
   import rbsm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  logic                step,
   input  logic                action,
   input  logic [LENGTH_W-1:0] length,
   output result_type          result
);

   logic [OFFSET_W-1:0] write_offset_ff, write_offset_in;
   logic [OFFSET_W-1:0] read_position_ff, read_position_in;
   logic [SIZE_W-1:0]   unread_bytes_ff, unread_bytes_in;

   logic [ALIGN_W-1:0]  shift;
   logic [ROUND_W-1:0]  mask;
   logic [ROUND_W-1:0]  len_r;
   logic [SIZE_W-1:0]   size;
   logic [SIZE_W-1:0]   free_b;
   logic [SIZE_W-1:0]   left;
   logic [SIZE_W-1:0]   wr_amount;
   logic [SIZE_W-1:0]   wr_sum;
   logic [SIZE_W-1:0]   rd_amount;
   logic [SIZE_W:0]     rd_sum;
   logic [STATUS_W-1:0] wr_status;

   always_comb begin
      shift = (cfg.align_log2 > MAX_ALIGN_LOG2) ? MAX_ALIGN_LOG2 : cfg.align_log2;
      mask  = (ROUND_W'(1) << shift) - ROUND_W'(1);
      len_r = (ROUND_W'(length) + mask) & ~mask;
      size  = (cfg.buffer_size > CAPACITY) ? CAPACITY : cfg.buffer_size;

      free_b = (size > unread_bytes_ff) ? size - unread_bytes_ff : '0;
      left   = (SIZE_W'(write_offset_ff) < size) ? size - SIZE_W'(write_offset_ff) : '0;

      // Write side: a rejected reservation grants nothing.
      wr_amount = '0;
      if (len_r > ROUND_W'(size)) begin
         wr_status = ST_TOO_LARGE;
      end else if (len_r > ROUND_W'(free_b)) begin
         wr_status = ST_NO_SPACE;
      end else begin
         wr_status = ST_OK;
         wr_amount = (len_r < ROUND_W'(left)) ? len_r[SIZE_W-1:0] : left;
      end
      wr_sum = SIZE_W'(write_offset_ff) + wr_amount;

      // Read side: the release never exceeds what is unread.
      rd_amount = (len_r < ROUND_W'(unread_bytes_ff)) ? len_r[SIZE_W-1:0] : unread_bytes_ff;
      rd_sum    = (SIZE_W+1)'(read_position_ff) + (SIZE_W+1)'(rd_amount);

      write_offset_in  = write_offset_ff;
      read_position_in = read_position_ff;
      unread_bytes_in  = unread_bytes_ff;
      result.status    = ST_OK;
      if (action == ACT_RESERVE) begin
         result.status       = wr_status;
         result.start_offset = write_offset_ff;
         result.granted      = wr_amount;
         if (wr_status == ST_OK) begin
            write_offset_in = (wr_sum >= size) ? '0 : wr_sum[OFFSET_W-1:0];
            unread_bytes_in = unread_bytes_ff + wr_amount;
         end
      end else begin
         result.start_offset = read_position_ff;
         result.granted      = rd_amount;
         read_position_in    = (rd_sum >= (SIZE_W+1)'(size)) ? '0 : rd_sum[OFFSET_W-1:0];
         unread_bytes_in     = unread_bytes_ff - rd_amount;
      end
      result.read_offset  = read_position_in;
      result.unread_count = unread_bytes_in;
      result.read_ready   = (unread_bytes_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_offset_ff  <= '0;
         read_position_ff <= '0;
         unread_bytes_ff  <= '0;
      end else if (step) begin
         write_offset_ff  <= write_offset_in;
         read_position_ff <= read_position_in;
         unread_bytes_ff  <= unread_bytes_in;
      end
   end

endmodule
